// ----- rtl/core/lsw_pkg.sv -----
// Package with the shared types and constants of the lidar scan wall segmenter.
`default_nettype none
package lsw_pkg;

    localparam int RANGE_W = 16;
    localparam int ANGLE_W = 16;
    localparam int IDX_W   = 12;
    localparam int STEP_W  = 14;
    localparam int SL_W    = 17;
    localparam int COORD_W = 17;
    localparam int TRIG_W  = 18;
    localparam int CFG_W   = 17;
    localparam int SQ_ITER = 26;

    localparam logic [16:0] POLY_A  = 17'd102944;
    localparam logic [16:0] POLY_B  = 17'd42047;
    localparam logic [16:0] POLY_C  = 17'd4639;
    localparam logic [15:0] QUARTER = 16'h4000;

    typedef enum logic [2:0] {
        CFG_RANGE_MIN,
        CFG_RANGE_MAX,
        CFG_ANGLE_START,
        CFG_ANGLE_STEP,
        CFG_GAP_LIMIT,
        CFG_SINE_LIMIT
    } t_cfg_idx;

    typedef enum logic [5:0] {
        OP_NONE, OP_ACCEPT, OP_ANG, OP_LD_CP, OP_LD_SP, OP_LD_CD, OP_LD_SD, OP_LD_CW,
        OP_TR0, OP_TR1, OP_TR2, OP_TR3, OP_TR4, OP_CX, OP_CY, OP_FIRST, OP_DIFF,
        OP_GSEL_PT, OP_GSEL_W, OP_G1, OP_G2, OP_G3, OP_G4, OP_G5, OP_G6, OP_GLIM,
        OP_GDEC, OP_P, OP_SQ_INIT, OP_SQ, OP_T1, OP_T2, OP_EMIT, OP_UPD, OP_POST,
        OP_WDEC, OP_CLEAR, OP_OUT
    } t_op;

    typedef enum logic [5:0] {
        S_IDLE, S_CHECK, S_ANG, S_LD_CP, S_CX, S_LD_SP, S_CY, S_FIRST, S_DIFF,
        S_LD_CD, S_LD_SD, S_LD_CW, S_TR0, S_TR1, S_TR2, S_TR3, S_TR4, S_GSEL_PT,
        S_GSEL_W, S_G1, S_G2, S_G3, S_G4, S_G5, S_G6, S_GLIM, S_GDEC, S_P,
        S_SQ_INIT, S_SQ, S_T1, S_T2, S_EMIT, S_UPD, S_POST, S_WDEC, S_CLEAR, S_OUT
    } t_state;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic ok;
        logic seen;
        logic eos;
        logic gap_big;
        logic p_ok;
        logic sq_last;
        logic out_empty;
    } t_stat;

    typedef struct packed {
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic                      closes;
    } t_seg;

endpackage
`default_nettype wire

// ----- rtl/core/lsw_ctrl.sv -----
// Sequencing state machine of the lidar scan wall segmenter.
`default_nettype none
module lsw_ctrl
    import lsw_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_stall
);

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   r_wrap, n_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_wrap  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_wrap  <= n_wrap;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_wrap  = r_wrap;
        unique case (r_state)
            S_IDLE: begin
                n_wrap = 1'b0;
                if (i_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK:   n_state = i_stat.ok ? S_ANG : S_POST;
            S_ANG:     n_state = S_LD_CP;
            S_LD_CP: begin
                n_state = S_TR0;
                n_ret   = S_CX;
            end
            S_CX:      n_state = S_LD_SP;
            S_LD_SP: begin
                n_state = S_TR0;
                n_ret   = S_CY;
            end
            S_CY:      n_state = i_stat.seen ? S_DIFF : S_FIRST;
            S_FIRST:   n_state = S_UPD;
            S_DIFF:    n_state = S_LD_CD;
            S_LD_CD: begin
                n_state = S_TR0;
                n_ret   = S_GSEL_PT;
            end
            S_LD_SD: begin
                n_state = S_TR0;
                n_ret   = S_P;
            end
            S_LD_CW: begin
                n_state = S_TR0;
                n_ret   = S_GSEL_W;
            end
            S_TR0:     n_state = S_TR1;
            S_TR1:     n_state = S_TR2;
            S_TR2:     n_state = S_TR3;
            S_TR3:     n_state = S_TR4;
            S_TR4:     n_state = r_ret;
            S_GSEL_PT: n_state = S_G1;
            S_GSEL_W:  n_state = S_G1;
            S_G1:      n_state = S_G2;
            S_G2:      n_state = S_G3;
            S_G3:      n_state = S_G4;
            S_G4:      n_state = S_G5;
            S_G5:      n_state = S_G6;
            S_G6:      n_state = S_GLIM;
            S_GLIM:    n_state = r_wrap ? S_WDEC : S_GDEC;
            S_GDEC:    n_state = i_stat.gap_big ? S_UPD : S_LD_SD;
            S_P:       n_state = i_stat.p_ok ? S_SQ_INIT : S_UPD;
            S_SQ_INIT: n_state = S_SQ;
            S_SQ:      n_state = i_stat.sq_last ? S_T1 : S_SQ;
            S_T1:      n_state = S_T2;
            S_T2:      n_state = S_EMIT;
            S_EMIT:    n_state = S_UPD;
            S_UPD:     n_state = S_POST;
            S_POST: begin
                if (i_stat.eos && i_stat.seen) begin
                    n_state = S_LD_CW;
                    n_wrap  = 1'b1;
                end else if (i_stat.eos) begin
                    n_state = S_CLEAR;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_WDEC:    n_state = S_CLEAR;
            S_CLEAR:   n_state = S_OUT;
            S_OUT:     n_state = i_stat.out_empty ? S_IDLE : S_OUT;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall  = (r_state != S_IDLE);
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_IDLE:    o_cmd.op = i_valid ? OP_ACCEPT : OP_NONE;
            S_ANG:     o_cmd.op = OP_ANG;
            S_LD_CP:   o_cmd.op = OP_LD_CP;
            S_CX:      o_cmd.op = OP_CX;
            S_LD_SP:   o_cmd.op = OP_LD_SP;
            S_CY:      o_cmd.op = OP_CY;
            S_FIRST:   o_cmd.op = OP_FIRST;
            S_DIFF:    o_cmd.op = OP_DIFF;
            S_LD_CD:   o_cmd.op = OP_LD_CD;
            S_LD_SD:   o_cmd.op = OP_LD_SD;
            S_LD_CW:   o_cmd.op = OP_LD_CW;
            S_TR0:     o_cmd.op = OP_TR0;
            S_TR1:     o_cmd.op = OP_TR1;
            S_TR2:     o_cmd.op = OP_TR2;
            S_TR3:     o_cmd.op = OP_TR3;
            S_TR4:     o_cmd.op = OP_TR4;
            S_GSEL_PT: o_cmd.op = OP_GSEL_PT;
            S_GSEL_W:  o_cmd.op = OP_GSEL_W;
            S_G1:      o_cmd.op = OP_G1;
            S_G2:      o_cmd.op = OP_G2;
            S_G3:      o_cmd.op = OP_G3;
            S_G4:      o_cmd.op = OP_G4;
            S_G5:      o_cmd.op = OP_G5;
            S_G6:      o_cmd.op = OP_G6;
            S_GLIM:    o_cmd.op = OP_GLIM;
            S_GDEC:    o_cmd.op = OP_GDEC;
            S_P:       o_cmd.op = OP_P;
            S_SQ_INIT: o_cmd.op = OP_SQ_INIT;
            S_SQ:      o_cmd.op = OP_SQ;
            S_T1:      o_cmd.op = OP_T1;
            S_T2:      o_cmd.op = OP_T2;
            S_EMIT:    o_cmd.op = OP_EMIT;
            S_UPD:     o_cmd.op = OP_UPD;
            S_POST:    o_cmd.op = OP_POST;
            S_WDEC:    o_cmd.op = OP_WDEC;
            S_CLEAR:   o_cmd.op = OP_CLEAR;
            S_OUT:     o_cmd.op = OP_OUT;
            default:   o_cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/lsw_dp.sv -----
// Datapath of the lidar scan wall segmenter with a shared multiplier and a serial square root.
`default_nettype none
module lsw_dp
    import lsw_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_cmd                      i_cmd,
    input  wire logic                      i_cfg_we,
    input  wire logic [2:0]                i_cfg_idx,
    input  wire logic [CFG_W-1:0]          i_cfg_data,
    input  wire logic [RANGE_W-1:0]        i_range_mm,
    input  wire logic                      i_sample_bad,
    input  wire logic                      i_end_of_scan,
    input  wire logic                      i_stall,
    output logic                           o_valid,
    output logic signed [COORD_W-1:0]      o_seg_begin_x,
    output logic signed [COORD_W-1:0]      o_seg_begin_y,
    output logic signed [COORD_W-1:0]      o_seg_end_x,
    output logic signed [COORD_W-1:0]      o_seg_end_y,
    output logic                           o_closes_scan,
    output logic                           o_last_of_run,
    output t_stat                          o_stat
);

    logic [15:0] r_rmin, r_rmax, r_astart, r_glimit;
    logic [STEP_W-1:0] r_astep;
    logic [SL_W-1:0] r_slimit;

    logic [IDX_W-1:0] r_count, r_prev_idx;
    logic r_seen;
    logic [RANGE_W-1:0] r_prev_r, r_org_r;
    logic signed [COORD_W-1:0] r_anc_x, r_anc_y, r_org_x, r_org_y;

    logic [RANGE_W-1:0] r_r, r_ga, r_gb;
    logic r_bad, r_eos;
    logic [ANGLE_W-1:0] r_base, r_d, r_ang;
    logic [1:0] r_quad;
    logic [15:0] r_x;
    logic [16:0] r_x2, r_t;
    logic signed [TRIG_W-1:0] r_trig;
    logic signed [COORD_W-1:0] r_px, r_py;
    logic [32:0] r_a;
    logic [31:0] r_rp;
    logic [48:0] r_b;
    logic [50:0] r_g2;
    logic [47:0] r_glim;
    logic [32:0] r_p;
    logic [51:0] r_v;
    logic [29:0] r_rem;
    logic [SQ_ITER-1:0] r_root;
    logic [4:0] r_sqc;
    logic [42:0] r_m;

    t_seg r_ob [2];
    logic [1:0] r_ocnt;
    logic r_ohd;

    logic [16:0] m_a, m_b;
    logic [33:0] m_p;
    logic c_neg;
    logic [16:0] c_mag;
    logic [IDX_W-1:0] steps;
    logic [14:0] f_fold;
    logic [18:0] s_raw;
    logic [16:0] s_cl;
    logic [16:0] v_rnd;
    logic signed [COORD_W-1:0] coord;
    logic [48:0] a16;
    logic [50:0] g2_n;
    logic [29:0] rem_sh, trial;
    logic [SQ_ITER-1:0] gc;
    logic emit_ok, wrap_ok, pop;
    t_seg seg_new, seg_out;

    assign c_neg = r_trig[TRIG_W-1];
    assign c_mag = c_neg ? 17'(-r_trig) : r_trig[16:0];
    assign steps = r_count - r_prev_idx;
    assign f_fold = r_ang[0 +: 14] == 14'd0 && r_ang[14] ? 15'h4000 :
                    (r_ang[14] ? 15'h4000 - {1'b0, r_ang[13:0]} : {1'b0, r_ang[13:0]});

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (i_cmd.op)
            OP_ANG:  begin m_a = {5'b0, r_count};      m_b = {3'b0, r_astep};  end
            OP_DIFF: begin m_a = {5'b0, steps};        m_b = {3'b0, r_astep};  end
            OP_TR1:  begin m_a = {1'b0, r_x};          m_b = {1'b0, r_x};      end
            OP_TR2:  begin m_a = POLY_C;               m_b = r_x2;             end
            OP_TR3:  begin m_a = r_t;                  m_b = r_x2;             end
            OP_TR4:  begin m_a = r_t;                  m_b = {1'b0, r_x};      end
            OP_CX, OP_CY: begin m_a = {1'b0, r_r};     m_b = c_mag;            end
            OP_G1:   begin m_a = {1'b0, r_ga};         m_b = {1'b0, r_ga};     end
            OP_G2:   begin m_a = {1'b0, r_gb};         m_b = {1'b0, r_gb};     end
            OP_G3:   begin m_a = {1'b0, r_ga};         m_b = {1'b0, r_gb};     end
            OP_G4:   begin m_a = {1'b0, r_rp[31:16]};  m_b = c_mag;            end
            OP_G5:   begin m_a = {1'b0, r_rp[15:0]};   m_b = c_mag;            end
            OP_GLIM: begin m_a = {1'b0, r_glimit};     m_b = {1'b0, r_glimit}; end
            OP_P:    begin m_a = {1'b0, r_r};          m_b = r_trig[16:0];     end
            OP_T1:   begin m_a = r_slimit;             m_b = {1'b0, gc[15:0]}; end
            OP_T2:   begin m_a = r_slimit;             m_b = {7'b0, gc[25:16]}; end
            default: begin m_a = '0;                   m_b = '0;               end
        endcase
    end

    assign m_p = 34'(m_a) * 34'(m_b);

    assign s_raw = m_p[33:15];
    assign s_cl  = (s_raw > 19'd65536) ? 17'd65536 : s_raw[16:0];
    assign v_rnd = 17'((m_p + 34'd32768) >> 16);
    assign coord = c_neg ? -$signed(v_rnd) : $signed(v_rnd);

    assign a16 = {r_a[32:0], 16'b0};
    always_comb begin
        if (c_neg) begin
            g2_n = 51'(a16) + {1'b0, r_b, 1'b0};
        end else if ({2'b0, a16} > {1'b0, r_b, 1'b0}) begin
            g2_n = 51'(a16) - {1'b0, r_b, 1'b0};
        end else begin
            g2_n = '0;
        end
    end

    assign rem_sh = {r_rem[27:0], r_v[51:50]};
    assign trial  = {2'b0, r_root, 2'b01};
    assign gc     = (r_root < 26'd256) ? 26'd256 : r_root;

    assign emit_ok = ({1'b0, r_p} <= {gc, 8'b0}) && ({2'b0, r_p, 8'b0} > r_m);
    assign wrap_ok = {3'b0, r_g2[47:0]} < {3'b0, r_glim} && r_g2[50:48] == 3'b0;

    always_comb begin
        seg_new.bx     = r_anc_x;
        seg_new.by     = r_anc_y;
        seg_new.ex     = r_px;
        seg_new.ey     = r_py;
        seg_new.closes = 1'b0;
        if (i_cmd.op == OP_WDEC) begin
            seg_new.ex     = r_org_x;
            seg_new.ey     = r_org_y;
            seg_new.closes = 1'b1;
        end
    end

    assign seg_out = r_ob[r_ohd];
    assign o_valid = (r_ocnt != 2'd0) && (i_cmd.op == OP_OUT);
    assign pop     = o_valid && !i_stall;
    assign o_seg_begin_x = seg_out.bx;
    assign o_seg_begin_y = seg_out.by;
    assign o_seg_end_x   = seg_out.ex;
    assign o_seg_end_y   = seg_out.ey;
    assign o_closes_scan = seg_out.closes;
    assign o_last_of_run = (r_ocnt == 2'd1);

    assign o_stat.ok        = !r_bad && r_r >= r_rmin && r_r <= r_rmax;
    assign o_stat.seen      = r_seen;
    assign o_stat.eos       = r_eos;
    assign o_stat.gap_big   = {1'b0, r_g2} > {4'b0, r_glim};
    assign o_stat.p_ok      = !c_neg && r_trig != '0 && r_r != '0;
    assign o_stat.sq_last   = (r_sqc == 5'(SQ_ITER - 1));
    assign o_stat.out_empty = (r_ocnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rmin     <= 16'd0;
            r_rmax     <= 16'hFFFF;
            r_astart   <= 16'd0;
            r_astep    <= 14'd182;
            r_glimit   <= 16'd100;
            r_slimit   <= 17'd32768;
            r_count    <= '0;
            r_seen     <= 1'b0;
            r_prev_r   <= '0;
            r_prev_idx <= '0;
            r_anc_x    <= '0;
            r_anc_y    <= '0;
            r_org_x    <= '0;
            r_org_y    <= '0;
            r_org_r    <= '0;
            r_ocnt     <= '0;
            r_ohd      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RANGE_MIN:   r_rmin   <= i_cfg_data[15:0];
                    CFG_RANGE_MAX:   r_rmax   <= i_cfg_data[15:0];
                    CFG_ANGLE_START: r_astart <= i_cfg_data[15:0];
                    CFG_ANGLE_STEP:  r_astep  <= i_cfg_data[STEP_W-1:0];
                    CFG_GAP_LIMIT:   r_glimit <= i_cfg_data[15:0];
                    CFG_SINE_LIMIT:  r_slimit <= i_cfg_data;
                    default: ;
                endcase
            end
            case (i_cmd.op)
                OP_ACCEPT: r_ohd <= 1'b0;
                OP_FIRST: begin
                    r_seen  <= 1'b1;
                    r_org_x <= r_px;
                    r_org_y <= r_py;
                    r_org_r <= r_r;
                    r_anc_x <= r_px;
                    r_anc_y <= r_py;
                end
                OP_GDEC: begin
                    if (o_stat.gap_big) begin
                        r_anc_x <= r_px;
                        r_anc_y <= r_py;
                    end
                end
                OP_EMIT: begin
                    if (emit_ok) begin
                        r_anc_x <= r_px;
                        r_anc_y <= r_py;
                        r_ocnt  <= r_ocnt + 2'd1;
                    end
                end
                OP_WDEC: begin
                    if (wrap_ok) begin
                        r_ocnt <= r_ocnt + 2'd1;
                    end
                end
                OP_UPD: begin
                    r_prev_r   <= r_r;
                    r_prev_idx <= r_count;
                end
                OP_POST: r_count <= r_count + 1'b1;
                OP_CLEAR: begin
                    r_count    <= '0;
                    r_seen     <= 1'b0;
                    r_prev_r   <= '0;
                    r_prev_idx <= '0;
                    r_anc_x    <= '0;
                    r_anc_y    <= '0;
                    r_org_x    <= '0;
                    r_org_y    <= '0;
                    r_org_r    <= '0;
                end
                OP_OUT: begin
                    if (pop) begin
                        r_ohd  <= ~r_ohd;
                        r_ocnt <= r_ocnt - 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_r   <= i_range_mm;
                r_bad <= i_sample_bad;
                r_eos <= i_end_of_scan;
            end
            OP_ANG:    r_base <= r_astart + m_p[15:0];
            OP_DIFF:   r_d    <= m_p[15:0];
            OP_LD_CP:  r_ang  <= r_base + QUARTER;
            OP_LD_SP:  r_ang  <= r_base;
            OP_LD_CD:  r_ang  <= r_d + QUARTER;
            OP_LD_SD:  r_ang  <= r_d;
            OP_LD_CW:  r_ang  <= {2'b0, r_astep} + QUARTER;
            OP_TR0: begin
                r_quad <= r_ang[15:14];
                r_x    <= {f_fold, 1'b0};
            end
            OP_TR1:    r_x2 <= m_p[31:15];
            OP_TR2:    r_t  <= POLY_B - m_p[31:15];
            OP_TR3:    r_t  <= POLY_A - m_p[31:15];
            OP_TR4:    r_trig <= r_quad[1] ? -$signed({1'b0, s_cl}) : $signed({1'b0, s_cl});
            OP_CX:     r_px <= coord;
            OP_CY:     r_py <= coord;
            OP_GSEL_PT: begin
                r_ga <= r_r;
                r_gb <= r_prev_r;
            end
            OP_GSEL_W: begin
                r_ga <= r_org_r;
                r_gb <= r_prev_r;
            end
            OP_G1:     r_a  <= m_p[32:0];
            OP_G2:     r_a  <= r_a + m_p[32:0];
            OP_G3:     r_rp <= m_p[31:0];
            OP_G4:     r_b  <= {m_p[32:0], 16'b0};
            OP_G5:     r_b  <= r_b + 49'(m_p[32:0]);
            OP_G6:     r_g2 <= g2_n;
            OP_GLIM:   r_glim <= {m_p[31:0], 16'b0};
            OP_P:      r_p  <= m_p[32:0];
            OP_SQ_INIT: begin
                r_v    <= {1'b0, r_g2};
                r_rem  <= '0;
                r_root <= '0;
                r_sqc  <= '0;
            end
            OP_SQ: begin
                r_v   <= {r_v[49:0], 2'b0};
                r_sqc <= r_sqc + 5'd1;
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[SQ_ITER-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[SQ_ITER-2:0], 1'b0};
                end
            end
            OP_T1:     r_m <= 43'(m_p[32:0]);
            OP_T2:     r_m <= r_m + {m_p[26:0], 16'b0};
            OP_EMIT: begin
                if (emit_ok) begin
                    r_ob[r_ocnt[0]] <= seg_new;
                end
            end
            OP_WDEC: begin
                if (wrap_ok) begin
                    r_ob[r_ocnt[0]] <= seg_new;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/lidar_scan_wall_segmenter.sv -----
// Top level of the lidar scan wall segmenter: controller, datapath and ports.
// Items are handled one at a time; the input stalls from acceptance until all results are taken.
// The stall is shortest for a skipped sample and longest for a later valid one, set by the shared
// multiplier and the 26-step square root.
// End of scan adds the closing test; each result adds its own output step, held while i_stall is high.
// Synchronous active-low reset restores the register defaults and clears all scan state.
`default_nettype none
module lidar_scan_wall_segmenter
    import lsw_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [2:0]                i_cfg_idx,
    input  wire logic [CFG_W-1:0]          i_cfg_data,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [RANGE_W-1:0]        i_range_mm,
    input  wire logic                      i_sample_bad,
    input  wire logic                      i_end_of_scan,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic signed [COORD_W-1:0]      o_seg_begin_x,
    output logic signed [COORD_W-1:0]      o_seg_begin_y,
    output logic signed [COORD_W-1:0]      o_seg_end_x,
    output logic signed [COORD_W-1:0]      o_seg_end_y,
    output logic                           o_closes_scan,
    output logic                           o_last_of_run
);

    t_cmd  cmd;
    t_stat stat;

    lsw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    lsw_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_range_mm    (i_range_mm),
        .i_sample_bad  (i_sample_bad),
        .i_end_of_scan (i_end_of_scan),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_seg_begin_x (o_seg_begin_x),
        .o_seg_begin_y (o_seg_begin_y),
        .o_seg_end_x   (o_seg_end_x),
        .o_seg_end_y   (o_seg_end_y),
        .o_closes_scan (o_closes_scan),
        .o_last_of_run (o_last_of_run),
        .o_stat        (stat)
    );

endmodule
`default_nettype wire

// ----- tb/lidar_scan_wall_segmenter_tb.sv -----
// Self-checking testbench for the lidar scan wall segmenter: directed table, random scans, predictor.
`default_nettype none
module lidar_scan_wall_segmenter_tb;
    import lsw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic                      closes;
        logic                      last;
    } t_exp_seg;

    typedef struct {
        int   range;
        bit   bad;
        bit   eos;
        int   n_typed;
        int   bx;
        int   by;
        int   ex;
        int   ey;
        bit   cl;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [2:0]             i_cfg_idx = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [RANGE_W-1:0]     i_range_mm = '0;
    logic                   i_sample_bad = 1'b0;
    logic                   i_end_of_scan = 1'b0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic signed [COORD_W-1:0] o_seg_begin_x, o_seg_begin_y, o_seg_end_x, o_seg_end_y;
    logic                   o_closes_scan, o_last_of_run;

    lidar_scan_wall_segmenter dut (.*);

    always #2 i_clk = ~i_clk;

    // Predictor copy of configuration and scan state.
    longint unsigned rmin, rmax, ang0, astep, gap_lim, sin_lim;
    longint unsigned sample_idx, prev_r, prev_idx, first_r;
    bit              have_point;
    longint          anc_x, anc_y, first_x, first_y;

    t_exp_seg segment_queue[$];
    int      errors = 0;
    int      items_sent = 0;
    int      segs_seen = 0;
    int      closes_seen = 0;
    int      idle_pct = 0;
    int      stall_pct = 0;

    function automatic longint sin_q16(longint unsigned ang);
        longint unsigned quad, f, x, x2, t, s;
        ang  = ang & 64'hFFFF;
        quad = (ang >> 14) & 3;
        f    = ang & 64'h3FFF;
        if (quad[0]) f = 64'd16384 - f;
        x  = f << 1;
        x2 = (x * x) >> 15;
        t  = (64'(POLY_C) * x2) >> 15;
        t  = 64'(POLY_B) - t;
        t  = (t * x2) >> 15;
        t  = 64'(POLY_A) - t;
        s  = (t * x) >> 15;
        if (s > 65536) s = 65536;
        return quad[1] ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint cos_q16(longint unsigned ang);
        return sin_q16(ang + 64'd16384);
    endfunction

    function automatic longint scale_coord(longint unsigned r, longint trig);
        longint unsigned mag;
        longint v;
        mag = (trig < 0) ? -trig : trig;
        v = longint'((r * mag + 64'd32768) >> 16);
        return (trig < 0) ? -v : v;
    endfunction

    function automatic longint unsigned chord_sq_q16(longint unsigned r, longint unsigned p,
                                                     longint c);
        longint unsigned a, b;
        a = (r * r + p * p) << 16;
        b = 64'd2 * r * p * longint'((c < 0) ? -c : c);
        if (c < 0) return a + b;
        return (a > b) ? a - b : 64'd0;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic void clear_scan();
        sample_idx = 0; have_point = 0; prev_r = 0; prev_idx = 0;
        anc_x = 0; anc_y = 0; first_x = 0; first_y = 0; first_r = 0;
    endfunction

    // Works out the segments caused by one sample and updates the scan state.
    function automatic int predict_segments(longint unsigned r, bit bad, bit eos,
                                            ref t_exp_seg segs[$]);
        longint unsigned idx, glim, ang, steps, d, g2, p, g, w;
        longint px, py, s;
        t_exp_seg sg;
        r    = r & 64'hFFFF;
        idx  = sample_idx % 4096;
        glim = (gap_lim * gap_lim) << 16;
        segs.delete();
        if (!bad && r >= rmin && r <= rmax) begin
            ang = (ang0 + idx * astep) & 64'hFFFF;
            px = scale_coord(r, cos_q16(ang));
            py = scale_coord(r, sin_q16(ang));
            if (!have_point) begin
                have_point = 1;
                first_x = px; first_y = py; first_r = r;
                anc_x = px; anc_y = py;
            end else begin
                steps = (idx + 4096 - prev_idx) % 4096;
                d  = (steps * astep) & 64'hFFFF;
                g2 = chord_sq_q16(r, prev_r, cos_q16(d));
                if (g2 > glim) begin
                    anc_x = px; anc_y = py;
                end else begin
                    s = sin_q16(d);
                    if (s > 0 && r > 0) begin
                        p = r * longint'(s);
                        g = int_sqrt(g2);
                        if (g < 256) g = 256;
                        if (p <= (g << 8) && p * 256 > sin_lim * g) begin
                            sg = '{anc_x, anc_y, px, py, 1'b0, 1'b0};
                            segs = {segs, sg};
                            anc_x = px; anc_y = py;
                        end
                    end
                end
            end
            prev_r = r;
            prev_idx = idx;
        end
        sample_idx = (idx + 1) % 4096;
        if (eos) begin
            if (have_point) begin
                w = chord_sq_q16(first_r, prev_r, cos_q16(astep));
                if (w < glim) begin
                    sg = '{anc_x, anc_y, first_x, first_y, 1'b1, 1'b0};
                    segs = {segs, sg};
                end
            end
            clear_scan();
        end
        if (segs.size() > 0) segs[segs.size()-1].last = 1'b1;
        return segs.size();
    endfunction

    task automatic write_regs(longint unsigned v_min, longint unsigned v_max,
                              longint unsigned v_start, longint unsigned v_step,
                              longint unsigned v_gap, longint unsigned v_sine);
        longint unsigned vals[6];
        vals = '{v_min, v_max, v_start, v_step, v_gap, v_sine};
        for (int k = 0; k < 6; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(k);
            i_cfg_data <= CFG_W'(vals[k]);
            @(posedge i_clk);
        end
        // An index past the register list must be ignored.
        i_cfg_idx  <= 3'(6 + $urandom_range(1));
        i_cfg_data <= CFG_W'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rmin    = v_min & 64'hFFFF;
        rmax    = v_max & 64'hFFFF;
        ang0    = v_start & 64'hFFFF;
        astep   = v_step & 64'h3FFF;
        gap_lim = v_gap & 64'hFFFF;
        sin_lim = v_sine & 64'h1FFFF;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (segment_queue.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    // Sends one item and queues what it should produce; typed rows override the prediction.
    task automatic send_sample(longint unsigned r, bit bad, bit eos, int n_typed = -1,
                               t_exp_seg typed = '{0, 0, 0, 0, 0, 0});
        t_exp_seg segs[$];
        int   n;
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_valid       <= 1'b1;
        i_range_mm    <= RANGE_W'(r);
        i_sample_bad  <= bad;
        i_end_of_scan <= eos;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        n = predict_segments(r, bad, eos, segs);
        if (n_typed >= 0) begin
            if (n != n_typed) begin
                $error("directed row: predictor gives %0d results, table %0d", n, n_typed);
                errors++;
            end
            segs.delete();
            if (n_typed == 1) segs = {segs, typed};
        end
        foreach (segs[k]) segment_queue = {segment_queue, segs[k]};
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_exp_seg e;
        if (i_rst_n && o_valid && !i_stall) begin
            segs_seen++;
            if (o_closes_scan) closes_seen++;
            if (segment_queue.size() == 0) begin
                $error("segment with no expectation waiting");
                errors++;
            end else begin
                e = segment_queue.pop_front();
                if (o_seg_begin_x !== e.bx) begin
                    $error("seg_begin_x expected %0d got %0d", e.bx, o_seg_begin_x); errors++;
                end
                if (o_seg_begin_y !== e.by) begin
                    $error("seg_begin_y expected %0d got %0d", e.by, o_seg_begin_y); errors++;
                end
                if (o_seg_end_x !== e.ex) begin
                    $error("seg_end_x expected %0d got %0d", e.ex, o_seg_end_x); errors++;
                end
                if (o_seg_end_y !== e.ey) begin
                    $error("seg_end_y expected %0d got %0d", e.ey, o_seg_end_y); errors++;
                end
                if (o_closes_scan !== e.closes) begin
                    $error("closes_scan expected %0d got %0d", e.closes, o_closes_scan);
                    errors++;
                end
                if (o_last_of_run !== e.last) begin
                    $error("last_of_run expected %0d got %0d", e.last, o_last_of_run);
                    errors++;
                end
            end
        end
    end

    // A wall-like scan: ranges walk slowly, with some bad, jumping and out-of-range samples.
    task automatic run_scan(int len);
        int r, pick;
        r = $urandom_range(300, 20000);
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(99);
            if (pick < 80) r = r + $urandom_range(80) - 40;
            else if (pick < 88) r = $urandom_range(65535);
            else if (pick < 92) r = $urandom_range(3) * 21845;
            if (r < 0) r = 0;
            if (r > 65535) r = 65535;
            send_sample(r, pick >= 95, k == len - 1);
        end
    endtask

    t_row table_rows[] = '{
        '{1000, 0, 1, 1, 1000, 0, 1000, 0, 1},
        '{0, 1, 1, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, -1, 0, 0, 0, 0, 0},
        '{30, 0, 0, -1, 0, 0, 0, 0, 0},
        '{60, 0, 0, -1, 0, 0, 0, 0, 0},
        '{90, 0, 0, -1, 0, 0, 0, 0, 0},
        '{5000, 0, 0, -1, 0, 0, 0, 0, 0},
        '{5010, 1, 0, 0, 0, 0, 0, 0, 0},
        '{5030, 0, 0, -1, 0, 0, 0, 0, 0},
        '{5060, 0, 0, -1, 0, 0, 0, 0, 0},
        '{65535, 0, 0, -1, 0, 0, 0, 0, 0},
        '{65535, 0, 0, -1, 0, 0, 0, 0, 0},
        '{65535, 0, 1, -1, 0, 0, 0, 0, 0},
        '{2000, 0, 0, -1, 0, 0, 0, 0, 0},
        '{2000, 0, 0, -1, 0, 0, 0, 0, 0},
        '{2010, 0, 0, -1, 0, 0, 0, 0, 0},
        '{2030, 0, 0, -1, 0, 0, 0, 0, 0},
        '{2040, 1, 0, 0, 0, 0, 0, 0, 0},
        '{2060, 0, 0, -1, 0, 0, 0, 0, 0},
        '{2080, 0, 1, -1, 0, 0, 0, 0, 0},
        '{40000, 1, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 1, -1, 0, 0, 0, 0, 0}
    };

    initial begin
        #40ms;
        $display("** lidar_scan_wall_segmenter: FAILED **");
        $finish;
    end

    initial begin
        t_exp_seg typed;
        int   guard;
        int   idle_modes[4] = '{0, 78, 0, 18};
        int   stall_modes[4] = '{0, 0, 78, 18};
        clear_scan();
        rmin = 0; rmax = 65535; ang0 = 0; astep = 182; gap_lim = 100; sin_lim = 32768;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[k]) begin
            typed = '{table_rows[k].bx, table_rows[k].by, table_rows[k].ex,
                      table_rows[k].ey, table_rows[k].cl, 1'b1};
            send_sample(table_rows[k].range, table_rows[k].bad, table_rows[k].eos,
                        table_rows[k].n_typed, typed);
        end
        wait_drained();

        for (int ph = 0; ph < 9; ph++) begin
            idle_pct  = idle_modes[ph % 4];
            stall_pct = stall_modes[ph % 4];
            case (ph)
                0: write_regs(0, 65535, 0, 182, 100, 32768);
                1: write_regs(500, 8000, $urandom, 182, 100, 32768);
                2: write_regs(0, 65535, $urandom, 1, 0, 0);
                3: write_regs(0, 65535, 65535, 16383, 65535, 65536);
                4: write_regs(40000, 100, $urandom, 300, 200, 30000);
                5: write_regs($urandom_range(2000), 65535 - $urandom_range(2000), $urandom,
                              16383 - $urandom_range(50), 65535, 65535);
                default: write_regs($urandom_range(400), $urandom_range(30000, 65535),
                                    $urandom, $urandom_range(1, 600),
                                    $urandom_range(20, 300), $urandom_range(65536));
            endcase
            for (int n = 0; n < 135; ) begin
                if ($urandom_range(9) == 0) begin
                    send_sample($urandom, $urandom_range(1), $urandom_range(1));
                    n++;
                end else begin
                    guard = $urandom_range(4, 40);
                    run_scan(guard);
                    n += guard;
                end
            end
            wait_drained();
        end

        i_valid <= 1'b0;
        guard = 0;
        while (segment_queue.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (200) @(posedge i_clk);
        if (segment_queue.size() != 0) begin
            $error("%0d expected segments never arrived", segment_queue.size());
            errors++;
        end
        $display("Sent %0d samples over a directed table and nine register settings;",
                 items_sent);
        $display("checked %0d segments, %0d of them closing a scan.", segs_seen, closes_seen);
        if (errors == 0) begin
            $display("** lidar_scan_wall_segmenter: PASSED **");
        end else begin
            $display("** lidar_scan_wall_segmenter: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
rtl/core/lsw_pkg.sv
rtl/core/lsw_ctrl.sv
rtl/core/lsw_dp.sv
rtl/core/lidar_scan_wall_segmenter.sv
tb/lidar_scan_wall_segmenter_tb.sv
